// File: src/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants of the 3x3 RGB convolution unit: pixel and
// transfer payloads, kernel packing and configuration register indexes.
// ----------------------------------------------------------------------------
package rgbc_pkg;

   // pixel and position widths
   localparam int PIX_W      = 8;
   localparam int POS_W      = 10;
   localparam int COEF_W     = 16;
   localparam int SIZE_CFG_W = 11;
   localparam int KROW_W     = 3 * COEF_W;

   // window geometry
   localparam int WIN_DIM  = 3;
   localparam int WIN_TAPS = WIN_DIM * WIN_DIM;
   localparam int MIN_SIZE = 3;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = KROW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd4;

   // register reset values
   localparam logic [SIZE_CFG_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
   localparam logic [SIZE_CFG_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
   localparam logic [KROW_W-1:0]     RST_KERNEL_TOP    = 48'h0;
   localparam logic [KROW_W-1:0]     RST_KERNEL_MIDDLE = 48'h0000_1000_0000;
   localparam logic [KROW_W-1:0]     RST_KERNEL_BOTTOM = 48'h0;

   // one rgb pixel, red in the low byte
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pix_type;

   // one line store entry: the two lines above the current one
   typedef struct packed {
      pix_type older;
      pix_type newer;
   } line_pair_type;

   // position and frame tag of a result
   typedef struct packed {
      logic [POS_W-1:0] centre_row;
      logic [POS_W-1:0] centre_column;
      logic             frame_last;
   } meta_type;

   typedef struct packed {
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic [POS_W-1:0] centre_row;
      logic [POS_W-1:0] centre_column;
      logic             frame_last;
   } rsp_type;

endpackage

// File: src/rgb_convolution_3x3_unit.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_unit
// 3x3 convolution of a raster-order RGB pixel stream with one shared kernel
// of signed Q4.12 taps, results for interior pixels only.
//
//   channel   direction  transfer rule              payload
//   req_      in         req_valid & !req_stall     req_type (pixel, frame_start)
//   rsp_      out        rsp_valid & !rsp_stall     rsp_type (rgb, position, last)
//   csr_      in         csr_valid & csr_ready      csr_index, csr_data
//
// One pixel per cycle unless a held result stalls the input. The line store is
// read at transfer and written back as the item leaves stage 1; a same-column
// read during that write is bypassed from the write.
// Reset clears counters, window and valids; line store content is
// undefined until written and needs no clearing pass.
// A stalled result freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_unit
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH      = 1024,
   parameter int MAX_HEIGHT     = 1024,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WCLG  = $clog2(MAX_WIDTH + 1);
   localparam int HCLG  = $clog2(MAX_HEIGHT + 1);
   localparam int WSZ_W = (WCLG > SIZE_CFG_W) ? WCLG : SIZE_CFG_W;
   localparam int HSZ_W = (HCLG > SIZE_CFG_W) ? HCLG : SIZE_CFG_W;
   localparam int RX_W  = POS_W + ROW_W;
   localparam int CX_W  = POS_W + CNT_W;

   // configuration registers
   logic [SIZE_CFG_W-1:0] width_ff;
   logic [SIZE_CFG_W-1:0] height_ff;
   logic [KROW_W-1:0]     ktop_ff;
   logic [KROW_W-1:0]     kmid_ff;
   logic [KROW_W-1:0]     kbot_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         ktop_ff   <= RST_KERNEL_TOP;
         kmid_ff   <= RST_KERNEL_MIDDLE;
         kbot_ff   <= RST_KERNEL_BOTTOM;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data[SIZE_CFG_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data[SIZE_CFG_W-1:0];
            CSR_KERNEL_TOP:    ktop_ff   <= csr_data[KROW_W-1:0];
            CSR_KERNEL_MIDDLE: kmid_ff   <= csr_data[KROW_W-1:0];
            CSR_KERNEL_BOTTOM: kbot_ff   <= csr_data[KROW_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size, clamped to 3..max
   logic [WSZ_W-1:0] w_eff;
   logic [HSZ_W-1:0] h_eff;

   always_comb begin
      if (WSZ_W'(width_ff) < WSZ_W'(MIN_SIZE)) begin
         w_eff = WSZ_W'(MIN_SIZE);
      end else if (WSZ_W'(width_ff) > WSZ_W'(MAX_WIDTH)) begin
         w_eff = WSZ_W'(MAX_WIDTH);
      end else begin
         w_eff = WSZ_W'(width_ff);
      end
      if (HSZ_W'(height_ff) < HSZ_W'(MIN_SIZE)) begin
         h_eff = HSZ_W'(MIN_SIZE);
      end else if (HSZ_W'(height_ff) > HSZ_W'(MAX_HEIGHT)) begin
         h_eff = HSZ_W'(MAX_HEIGHT);
      end else begin
         h_eff = HSZ_W'(height_ff);
      end
   end

   // handshake: the pipeline advances unless a result is held
   logic adv;
   logic acc;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign acc       = req_valid && !req_stall;

   // raster position of the arriving pixel
   logic [CNT_W-1:0] col_ff, col_in, c_cur;
   logic [ROW_W-1:0] row_ff, row_in, r_cur;
   logic             col_last, row_last;
   logic             emit_cur;
   logic [RX_W-1:0]  r_m1;
   logic [CX_W-1:0]  c_m1;
   meta_type         meta_cur;

   always_comb begin
      c_cur    = req_data.frame_start ? '0 : col_ff;
      r_cur    = req_data.frame_start ? '0 : row_ff;
      col_last = (WSZ_W'(c_cur) + WSZ_W'(1)) >= w_eff;
      row_last = (HSZ_W'(r_cur) + HSZ_W'(1)) >= h_eff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : r_cur + 1'b1;
      end else begin
         col_in = c_cur + 1'b1;
         row_in = r_cur;
      end
      emit_cur = (r_cur >= ROW_W'(2)) && (c_cur >= CNT_W'(2));
      r_m1     = RX_W'(r_cur) - RX_W'(1);
      c_m1     = CX_W'(c_cur) - CX_W'(1);
      meta_cur.centre_row    = r_m1[POS_W-1:0];
      meta_cur.centre_column = c_m1[POS_W-1:0];
      meta_cur.frame_last    = (HSZ_W'(r_cur) == h_eff - 1'b1)
                            && (WSZ_W'(c_cur) == w_eff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store read in flight
   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic [CNT_W-1:0] s1_col_ff;
   pix_type          s1_pix_ff;
   meta_type         s1_meta_ff;
   pix_type          pix_cur;

   assign pix_cur = '{blue: req_data.in_blue, green: req_data.in_green,
                      red: req_data.in_red};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_emit_ff <= emit_cur;
         s1_col_ff  <= c_cur;
         s1_pix_ff  <= pix_cur;
         s1_meta_ff <= meta_cur;
      end
   end

   line_pair_type lm_rd;

   rgbc_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (acc),
      .rd_addr (c_cur),
      .wr_en   (s1_valid_ff && adv),
      .wr_addr (s1_col_ff),
      .wr_pix  (s1_pix_ff),
      .rd_data (lm_rd)
   );

   // stage 2: window holds the item's 3x3 neighborhood
   pix_type [WIN_TAPS-1:0] taps;

   rgbc_window u_window (
      .clock  (clock),
      .reset  (reset),
      .shift  (s1_valid_ff && adv),
      .above2 (lm_rd.older),
      .above1 (lm_rd.newer),
      .pix    (s1_pix_ff),
      .taps   (taps)
   );

   // kernel taps unpacked, first tap of a row weighs the leftmost column
   logic [WIN_TAPS-1:0][COEF_W-1:0] coef;

   always_comb begin
      for (int k = 0; k < WIN_DIM; k++) begin
         coef[k]             = ktop_ff[k*COEF_W +: COEF_W];
         coef[WIN_DIM + k]   = kmid_ff[k*COEF_W +: COEF_W];
         coef[2*WIN_DIM + k] = kbot_ff[k*COEF_W +: COEF_W];
      end
   end

   // one filter per color channel
   logic [2:0][PIX_W-1:0] chan_res;

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [WIN_TAPS-1:0][PIX_W-1:0] chan_px;

      always_comb begin
         for (int k = 0; k < WIN_TAPS; k++) begin
            chan_px[k] = taps[k][ch*PIX_W +: PIX_W];
         end
      end

      rgbc_filter #(
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_filter (
         .clock  (clock),
         .adv    (adv),
         .px     (chan_px),
         .coef   (coef),
         .result (chan_res[ch])
      );
   end

   // valid and position pipeline alongside the filters
   logic     v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   meta_type m2_ff, m3_ff, m4_ff, rsp_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v2_ff        <= s1_valid_ff && s1_emit_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_ff       <= s1_meta_ff;
         m3_ff       <= m2_ff;
         m4_ff       <= m3_ff;
         rsp_meta_ff <= m4_ff;
      end
   end

   // result transfer
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{out_red:       chan_res[0],
                        out_green:     chan_res[1],
                        out_blue:      chan_res[2],
                        centre_row:    rsp_meta_ff.centre_row,
                        centre_column: rsp_meta_ff.centre_column,
                        frame_last:    rsp_meta_ff.frame_last};

   // column counter either wraps or steps by one per transfer
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      acc |=> ((col_ff == '0) || (col_ff == CNT_W'($past(c_cur) + 1'b1))))
      else $error("column counter skipped a position");

   // frame start puts the pixel in flight at column zero
   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.frame_start) |=> ((s1_col_ff == '0) && s1_valid_ff))
      else $error("frame start did not restart at column zero");

   // a result appears only after passing the row sum stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v4_ff))
      else $error("result valid without a filtered item");

endmodule

// File: src/rgbc_line_mem.sv
// ----------------------------------------------------------------------------
// rgbc_line_mem
// Line store of the two previous lines, one entry per column. Each pixel
// reads its column and writes it back from the read register, lines moved
// up by one. A read of the column being written gets the new entry.
// ----------------------------------------------------------------------------
module rgbc_line_mem
   import rgbc_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pix_type             wr_pix,
   output line_pair_type       rd_data
);

   line_pair_type mem [DEPTH];
   line_pair_type rd_ff;
   line_pair_type wr_data;

   // write back: newer line moves to older, arriving pixel becomes newer
   assign wr_data = '{older: rd_ff.newer, newer: wr_pix};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read with bypass of a write to the same column
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

// File: src/rgbc_window.sv
// ----------------------------------------------------------------------------
// rgbc_window
// 3x3 pixel window. Each pixel shifts the columns left and loads the new
// right column: two lines above from the line store, then the pixel itself.
// ----------------------------------------------------------------------------
module rgbc_window
   import rgbc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  pix_type                     above2,
   input  pix_type                     above1,
   input  pix_type                     pix,
   output pix_type [WIN_TAPS-1:0]      taps
);

   pix_type [WIN_TAPS-1:0] taps_ff;
   pix_type [WIN_TAPS-1:0] taps_in;

   // shift left within each row, new right column
   always_comb begin
      for (int row = 0; row < WIN_DIM; row++) begin
         for (int col = 0; col < WIN_DIM - 1; col++) begin
            taps_in[row*WIN_DIM + col] = taps_ff[row*WIN_DIM + col + 1];
         end
      end
      taps_in[WIN_DIM - 1]            = above2;
      taps_in[2*WIN_DIM - 1]          = above1;
      taps_in[WIN_TAPS - 1]           = pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
      end else if (shift) begin
         taps_ff <= taps_in;
      end
   end

   assign taps = taps_ff;

endmodule

// File: src/rgbc_filter.sv
// ----------------------------------------------------------------------------
// rgbc_filter
// Kernel filter of one color channel: nine products, row sums, total,
// floor shift by the coefficient fraction and saturation to 0..255.
// Three register stages, all advancing together.
// ----------------------------------------------------------------------------
module rgbc_filter
   import rgbc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic [WIN_TAPS-1:0][PIX_W-1:0]     px,
   input  logic [WIN_TAPS-1:0][COEF_W-1:0]    coef,
   output logic [PIX_W-1:0]                   result
);

   localparam int PROD_W = PIX_W + 1 + COEF_W;
   localparam int RSUM_W = PROD_W + 2;
   localparam int SUM_W  = PROD_W + 4;

   logic signed [PROD_W-1:0] prod_ff [WIN_TAPS];
   logic signed [RSUM_W-1:0] rsum_ff [WIN_DIM];
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  scaled;
   logic [PIX_W-1:0]         sat_in;
   logic [PIX_W-1:0]         result_ff;

   // products of pixel and signed coefficient
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < WIN_TAPS; k++) begin
            prod_ff[k] <= $signed({1'b0, px[k]}) * $signed(coef[k]);
         end
      end
   end

   // sum per kernel row
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < WIN_DIM; r++) begin
            rsum_ff[r] <= RSUM_W'(prod_ff[r*WIN_DIM])
                        + RSUM_W'(prod_ff[r*WIN_DIM + 1])
                        + RSUM_W'(prod_ff[r*WIN_DIM + 2]);
         end
      end
   end

   // total, floor shift and clamp
   always_comb begin
      total  = SUM_W'(rsum_ff[0]) + SUM_W'(rsum_ff[1]) + SUM_W'(rsum_ff[2]);
      scaled = total >>> COEF_FRAC_BITS;
      if (total[SUM_W-1]) begin
         sat_in = '0;
      end else if (scaled > SUM_W'(255)) begin
         sat_in = '1;
      end else begin
         sat_in = scaled[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= sat_in;
      end
   end

   assign result = result_ff;

endmodule

// File: verif/rgbc_checker.sv
// ----------------------------------------------------------------------------
// rgbc_checker
// Watches the pixel, result and register channels of the 3x3 RGB convolution
// unit. Keeps its own line stores, window and counters, predicts the result of
// every interior pixel and compares each result transfer, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgbc_checker
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH      = 1024,
   parameter int MAX_HEIGHT     = 1024,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int PIX_MAX    = (1 << PIX_W) - 1;
   localparam int REPORT_MAX = 10;

   // register copies
   logic [SIZE_CFG_W-1:0] cfg_width;
   logic [SIZE_CFG_W-1:0] cfg_height;
   logic [KROW_W-1:0]     kernel_rows [WIN_DIM];

   // line stores, window and raster position of the next pixel
   pix_type     older_line [MAX_WIDTH];
   pix_type     newer_line [MAX_WIDTH];
   pix_type     win_px [WIN_TAPS];
   int unsigned col_pos;
   int unsigned row_pos;

   rsp_type expected_pixels [$];
   int      mismatches = 0;

   function automatic int unsigned clamp_size(input int unsigned size,
                                              input int unsigned limit);
      if (size < MIN_SIZE) return MIN_SIZE;
      if (size > limit) return limit;
      return size;
   endfunction

   // weighted sum of one channel over the window, floor shift, clip to a byte
   function automatic logic [PIX_W-1:0] filter_channel(input int chan);
      longint                   acc;
      logic signed [COEF_W-1:0] tap;
      acc = 0;
      for (int k = 0; k < WIN_TAPS; k++) begin
         tap = kernel_rows[k / WIN_DIM][(k % WIN_DIM) * COEF_W +: COEF_W];
         acc += longint'(tap) * longint'(win_px[k][chan * PIX_W +: PIX_W]);
      end
      if (acc <= 0) return '0;
      acc = acc >>> COEF_FRAC_BITS;
      return (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : acc[PIX_W-1:0];
   endfunction

   // one accepted pixel: update stores and window, queue the interior result
   task automatic convolve_pixel(input req_type item);
      pix_type     px;
      pix_type     above2;
      pix_type     above1;
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      rsp_type     res;
      px.red   = item.in_red;
      px.green = item.in_green;
      px.blue  = item.in_blue;
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      w   = clamp_size(cfg_width, MAX_WIDTH);
      h   = clamp_size(cfg_height, MAX_HEIGHT);
      c   = col_pos;
      r   = row_pos;
      idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;

      above2          = older_line[idx];
      above1          = newer_line[idx];
      older_line[idx] = above1;
      newer_line[idx] = px;

      // slide the window one column left, new column on the right
      for (int row = 0; row < WIN_DIM; row++) begin
         win_px[row * WIN_DIM]     = win_px[row * WIN_DIM + 1];
         win_px[row * WIN_DIM + 1] = win_px[row * WIN_DIM + 2];
      end
      win_px[2] = above2;
      win_px[5] = above1;
      win_px[8] = px;

      if (r >= 2 && c >= 2) begin
         res.out_red       = filter_channel(0);
         res.out_green     = filter_channel(1);
         res.out_blue      = filter_channel(2);
         res.centre_row    = POS_W'(r - 1);
         res.centre_column = POS_W'(c - 1);
         res.frame_last    = (r == h - 1) && (c == w - 1);
         expected_pixels.push_back(res);
      end

      // raster advance, wrapping at end of line and frame
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         cfg_width      = RST_IMAGE_WIDTH;
         cfg_height     = RST_IMAGE_HEIGHT;
         kernel_rows[0] = RST_KERNEL_TOP;
         kernel_rows[1] = RST_KERNEL_MIDDLE;
         kernel_rows[2] = RST_KERNEL_BOTTOM;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
         end
         for (int k = 0; k < WIN_TAPS; k++) win_px[k] = '0;
         col_pos = 0;
         row_pos = 0;
         expected_pixels.delete();
      end else begin
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   cfg_width = csr_data[SIZE_CFG_W-1:0];
               CSR_IMAGE_HEIGHT:  cfg_height = csr_data[SIZE_CFG_W-1:0];
               CSR_KERNEL_TOP:    kernel_rows[0] = csr_data;
               CSR_KERNEL_MIDDLE: kernel_rows[1] = csr_data;
               CSR_KERNEL_BOTTOM: kernel_rows[2] = csr_data;
               default: ;
            endcase
         end

         // pixel transfer
         if (req_valid && !req_stall) convolve_pixel(req_data);

         // result transfer
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("%0t: result with none expected: rgb %02x %02x %02x row %0d col %0d last %0d",
                           $realtime, rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                           rsp_data.centre_row, rsp_data.centre_column, rsp_data.frame_last);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green ||
                   rsp_data.out_blue !== want.out_blue ||
                   rsp_data.centre_row !== want.centre_row ||
                   rsp_data.centre_column !== want.centre_column ||
                   rsp_data.frame_last !== want.frame_last) begin
                  if (mismatches < REPORT_MAX) begin
                     $display("%0t: result mismatch, expected rgb %02x %02x %02x row %0d col %0d last %0d",
                              $realtime, want.out_red, want.out_green, want.out_blue,
                              want.centre_row, want.centre_column, want.frame_last);
                     $display("%0t:                     actual rgb %02x %02x %02x row %0d col %0d last %0d",
                              $realtime, rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                              rsp_data.centre_row, rsp_data.centre_column, rsp_data.frame_last);
                  end
                  mismatches++;
               end
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_pixels.size();
   end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the 3x3 RGB convolution unit. A short directed frame set with
// clamped sizes and extreme taps, the opening lines of one tall and one wide
// frame at the maximum sizes, then random raster frames under random kernels
// and sizes, with size changes in the middle of a frame and stray frame
// starts. Both channels idle in random bursts; results are checked by
// rgbc_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import rgbc_pkg::*;

   localparam int FRAME_MAX     = 1024;
   localparam int HOLD_OFF      = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int TALL_ROWS     = 80;
   localparam int WIDE_PIXELS   = 128;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int          mismatch_count;
   int          pending_count;
   int unsigned req_gap_odds = 0;
   bit          quiet_tail = 1'b0;

   rgb_convolution_3x3_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rgbc_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      #15_000_000;
      $display("FAILURE");
      $finish;
   end

   // result backpressure in bursts, stretches of varying density
   initial begin : rsp_backpressure
      int unsigned odds;
      odds = 0;
      forever begin
         @(posedge clock);
         if (quiet_tail) odds = 0;
         else if ($urandom_range(0, 99) == 0) odds = $urandom_range(0, 2);
         if (odds != 0 && $urandom_range(0, 7) < odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int unsigned active_width(input logic [SIZE_CFG_W-1:0] w);
      if (w < MIN_SIZE) return MIN_SIZE;
      if (w > FRAME_MAX) return FRAME_MAX;
      return w;
   endfunction

   // mostly moderate taps, sometimes any 16-bit value
   function automatic logic [COEF_W-1:0] random_tap();
      logic [COEF_W-1:0] mag;
      mag = COEF_W'($urandom_range(0, 'h0C00));
      if ($urandom_range(0, 3) == 0) return COEF_W'($urandom);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [KROW_W-1:0] random_kernel_row();
      return {random_tap(), random_tap(), random_tap()};
   endfunction

   function automatic logic [PIX_W-1:0] random_level();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // one pixel transfer, valid stays high afterwards
   task automatic push_pixel(input req_type item);
      if (req_gap_odds != 0 && $urandom_range(0, 15) < req_gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // raster pixels with random content, optional stray frame starts
   task automatic run_pixels(input int unsigned count, input bit open_frame,
                             input bit strays);
      req_type item;
      for (int unsigned i = 0; i < count; i++) begin
         item.in_red      = random_level();
         item.in_green    = random_level();
         item.in_blue     = random_level();
         item.frame_start = (i == 0 && open_frame) || (strays && $urandom_range(0, 59) == 0);
         push_pixel(item);
      end
   endtask

   // register write transfer, valid left high for the next one
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [SIZE_CFG_W-1:0] width_cfg,
                            input logic [SIZE_CFG_W-1:0] height_cfg,
                            input logic [KROW_W-1:0] ktop,
                            input logic [KROW_W-1:0] kmid,
                            input logic [KROW_W-1:0] kbot,
                            input bit noisy);
      logic [CSR_DATA_W-1:0] noise;
      // unused upper bits of the size registers carry junk when noisy
      noise = noisy ? CSR_DATA_W'({$urandom, $urandom}) : '0;
      write_csr(CSR_IMAGE_WIDTH, {noise[CSR_DATA_W-1:SIZE_CFG_W], width_cfg});
      write_csr(CSR_IMAGE_HEIGHT, {noise[CSR_DATA_W-1:SIZE_CFG_W], height_cfg});
      write_csr(CSR_KERNEL_TOP, ktop);
      write_csr(CSR_KERNEL_MIDDLE, kmid);
      write_csr(CSR_KERNEL_BOTTOM, kbot);
      csr_valid <= 1'b0;
   endtask

   // stop sending, wait for every result, then let in-flight pixels retire
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (HOLD_OFF) begin
         @(posedge clock);
         while (rsp_stall) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic [SIZE_CFG_W-1:0] width_cfg;
      logic [SIZE_CFG_W-1:0] height_cfg;
      logic [SIZE_CFG_W-1:0] last_width;
      logic [KROW_W-1:0]     ktop;
      logic [KROW_W-1:0]     kmid;
      logic [KROW_W-1:0]     kbot;
      bit                    resume_frame;
      req_type               item;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: sizes below the minimum, extreme taps, saturated pixels,
      // frame wrap without a frame start, frame start in mid frame
      configure(11'd0, 11'd2, {16'h0001, 16'h8000, 16'h7FFF},
                {16'hFFFF, 16'h1000, 16'h0000}, {16'h0000, 16'h7FFF, 16'h8000}, 1'b0);
      for (int i = 0; i < 24; i++) begin
         if (i < 9) begin
            item.in_red   = '1;
            item.in_green = '1;
            item.in_blue  = '1;
         end else if (i < 18) begin
            item.in_red   = (i % 2) ? 8'hFF : 8'h00;
            item.in_green = (i % 2) ? 8'h00 : 8'hFF;
            item.in_blue  = (i % 3 == 0) ? 8'hFF : 8'h00;
         end else begin
            item.in_red   = 8'(i * 37);
            item.in_green = 8'h80;
            item.in_blue  = 8'h7F;
         end
         item.frame_start = (i == 0) || (i == 21);
         push_pixel(item);
      end
      drain();

      // tall frame: width clamped up, maximum height, first rows only
      req_gap_odds = 1;
      configure(11'd2, 11'd1024, random_kernel_row(), random_kernel_row(),
                random_kernel_row(), 1'b0);
      run_pixels(MIN_SIZE * TALL_ROWS, 1'b1, 1'b0);
      drain();

      // wide frame: width above the maximum, start of the first line only
      configure(11'd2047, 11'd3, random_kernel_row(), random_kernel_row(),
                random_kernel_row(), 1'b1);
      run_pixels(WIDE_PIXELS, 1'b1, 1'b0);
      last_width = 11'd2047;

      // random frames; some phases go on with the open frame after a size change
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         if (p == 0) width_cfg = 11'd14;
         else if (p == 1) width_cfg = 11'd5;
         else if ($urandom_range(0, 7) == 0) width_cfg = SIZE_CFG_W'($urandom_range(0, 2));
         else width_cfg = SIZE_CFG_W'($urandom_range(3, 14));
         case ($urandom_range(0, 9))
            0:       height_cfg = SIZE_CFG_W'($urandom_range(0, 2));
            1:       height_cfg = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            default: height_cfg = SIZE_CFG_W'($urandom_range(3, 8));
         endcase
         if (p == 2) begin
            ktop = RST_KERNEL_TOP;
            kmid = RST_KERNEL_MIDDLE;
            kbot = RST_KERNEL_BOTTOM;
         end else begin
            ktop = random_kernel_row();
            kmid = random_kernel_row();
            kbot = random_kernel_row();
         end
         // only a narrower or equal line may continue the open frame
         resume_frame = (p == 1) || (p > 1 && $urandom_range(0, 2) == 0);
         if (p == 0 || active_width(width_cfg) > active_width(last_width))
            resume_frame = 1'b0;
         configure(width_cfg, height_cfg, ktop, kmid, kbot, 1'b1);
         if (p == RANDOM_PHASES - 1) begin
            req_gap_odds = 0;
            quiet_tail   = 1'b1;
         end else begin
            req_gap_odds = $urandom_range(0, 3);
         end
         run_pixels($urandom_range(100, 125), !resume_frame, 1'b1);
         last_width = width_cfg;
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
